@@ design/pcdp_pkg.sv @@
package pcdp_pkg;

  localparam int CHANNELS = 5;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int CHAN_W = 3;
  localparam int TIME_W = 32;
  localparam int TIMEOUT_W = 16;
  localparam int DUTY_W = 14;
  localparam int STATUS_W = 2;
  localparam int NUM_W = TIME_W + DUTY_W;
  localparam int TOL_W = TIME_W + 4;
  localparam int DIV_CNT_W = $clog2(DUTY_W + 1);

  localparam int IN_DATA_W = 4 * TIME_W;
  localparam int IN_USER_W = CHAN_W + 1;
  localparam int OUT_DATA_W = ((DUTY_W + TIME_W + 7) / 8) * 8;
  localparam int OUT_USER_W = CHAN_W + STATUS_W;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(20);
  localparam logic [DUTY_W-1:0] DUTY_SCALE = DUTY_W'(10000);
  localparam logic [3:0] TOL_NUM = 4'd11;
  localparam logic [3:0] TOL_DEN = 4'd10;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ACCEPT = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_WAIT   = 2'd2,
    STAT_LOST   = 2'd3
  } status_t;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] period;
    logic [NUM_W-1:0]  num;
  } chk_result_t;

endpackage

@@ design/pcdp_edge_check.sv @@
module pcdp_edge_check
  import pcdp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [IN_DATA_W-1:0] edges,
  output logic                 done,
  output chk_result_t          result
);

  logic [5:0] step;

  logic [TIME_W-1:0] r1, r2, f1, f2;

  logic              ne_all;
  logic [TIME_W-1:0] p, p1;
  logic [TIME_W-1:0] drf1, dfr1, drf2, dfr2;
  logic              r1_lt_f1;
  logic              order_rise, order_fall;

  logic              tol_ok;
  logic [TIME_W-1:0] period;
  logic [TIME_W:0]   high_sum, low_sum;

  logic              rise_first, pos_ok;

  logic              pre_valid;
  logic [TIME_W-1:0] high;

  logic [TOL_W-1:0]  p_hi, p_lo, p1_hi, p1_lo;
  logic [TIME_W:0]   period_sum;
  logic [TIME_W-1:0] low_val;
  logic              order_ok_next, rf_next, pos_ok_next;
  logic              lt_f1_r2, lt_r2_f2, lt_f1_r1, lt_r1_f2, lt_f2_r2, lt_r2_f1, lt_f2_r1;

  assign lt_f1_r2 = f1 < r2;
  assign lt_r2_f2 = r2 < f2;
  assign lt_f1_r1 = f1 < r1;
  assign lt_r1_f2 = r1 < f2;
  assign lt_f2_r2 = f2 < r2;
  assign lt_r2_f1 = r2 < f1;
  assign lt_f2_r1 = f2 < r1;

  assign p_hi = TOL_W'(p) * TOL_W'(TOL_NUM);
  assign p_lo = TOL_W'(p) * TOL_W'(TOL_DEN);
  assign p1_hi = TOL_W'(p1) * TOL_W'(TOL_NUM);
  assign p1_lo = TOL_W'(p1) * TOL_W'(TOL_DEN);
  assign period_sum = {1'b0, p} + {1'b0, p1};
  assign low_val = low_sum[TIME_W:1];

  always_comb begin
    if (r1_lt_f1) begin
      if (drf1 < period) begin
        rf_next = 1'b1;
        pos_ok_next = 1'b1;
      end else if (dfr1 < period) begin
        rf_next = 1'b0;
        pos_ok_next = 1'b1;
      end else begin
        rf_next = 1'b0;
        pos_ok_next = 1'b0;
      end
    end else begin
      if (dfr1 < period) begin
        rf_next = 1'b0;
        pos_ok_next = 1'b1;
      end else if (drf1 < period) begin
        rf_next = 1'b1;
        pos_ok_next = 1'b1;
      end else begin
        rf_next = 1'b0;
        pos_ok_next = 1'b0;
      end
    end
  end

  assign order_ok_next = rise_first ? order_rise : order_fall;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= {step[4:0], start};
    end

    if (start) begin
      r1 <= edges[TIME_W-1:0];
      r2 <= edges[2*TIME_W-1:TIME_W];
      f1 <= edges[3*TIME_W-1:2*TIME_W];
      f2 <= edges[4*TIME_W-1:3*TIME_W];
    end

    if (step[0]) begin
      ne_all <= (r1 != r2) && (r1 != f1) && (r1 != f2) &&
                (r2 != f1) && (r2 != f2) && (f1 != f2);
      p <= r2 - r1;
      p1 <= f2 - f1;
      drf1 <= f1 - r1;
      dfr1 <= r1 - f1;
      drf2 <= f2 - r2;
      dfr2 <= r2 - f2;
      r1_lt_f1 <= r1 < f1;
      if (r1 < f1 && lt_f1_r2 && lt_r2_f2) begin
        order_rise <= 1'b1;
      end else if (lt_f1_r1) begin
        order_rise <= lt_f1_r2 && lt_r2_f2;
      end else if (lt_r2_f1) begin
        order_rise <= !lt_f2_r2;
      end else begin
        order_rise <= !lt_r2_f2;
      end
      if (lt_f1_r1 && lt_r1_f2 && lt_f2_r2) begin
        order_fall <= 1'b1;
      end else if (r1 < f1) begin
        order_fall <= lt_r1_f2 && lt_f2_r2;
      end else if (lt_f2_r1) begin
        order_fall <= !lt_r2_f2;
      end else begin
        order_fall <= !lt_f2_r2;
      end
    end

    if (step[1]) begin
      tol_ok <= (p_hi > p1_lo) && (p1_hi > p_lo);
      period <= period_sum[TIME_W:1];
      high_sum <= {1'b0, drf1} + {1'b0, drf2};
      low_sum <= {1'b0, dfr1} + {1'b0, dfr2};
    end

    if (step[2]) begin
      rise_first <= rf_next;
      pos_ok <= pos_ok_next;
    end

    if (step[3]) begin
      if (rise_first) begin
        high <= high_sum[TIME_W:1];
        pre_valid <= ne_all && tol_ok && pos_ok && order_ok_next;
      end else begin
        high <= period - low_val;
        pre_valid <= ne_all && tol_ok && pos_ok && order_ok_next && !(low_val > period);
      end
    end

    if (step[4]) begin
      result.valid <= pre_valid && (period != '0) && !(high > period);
      result.period <= period;
      result.num <= NUM_W'(high) * NUM_W'(DUTY_SCALE);
    end
  end

  assign done = step[5];

endmodule

@@ design/pcdp_divider.sv @@
module pcdp_divider
  import pcdp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [TIME_W-1:0] den,
  output logic              done,
  output logic [DUTY_W-1:0] quo
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [TIME_W-1:0]    rem;
  logic [DUTY_W-1:0]    low_bits;
  logic [TIME_W-1:0]    divisor;

  logic [TIME_W:0] trial;
  logic [TIME_W:0] diff;
  logic            ge;

  assign trial = {rem, low_bits[DUTY_W-1]};
  assign ge = trial >= {1'b0, divisor};
  assign diff = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= DIV_CNT_W'(DUTY_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end

    if (start) begin
      rem <= num[NUM_W-1:DUTY_W];
      low_bits <= num[DUTY_W-1:0];
      divisor <= den;
    end else if (busy) begin
      rem <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      low_bits <= {low_bits[DUTY_W-2:0], 1'b0};
      quo <= {quo[DUTY_W-2:0], ge};
    end
  end

endmodule

@@ design/pwm_capture_duty_period_unit.sv @@
// Channel   Dir  Handshake                  Payload (low bit first)
// s_axis    in   s_axis_tvalid/tready       tuser: channel, captures_ready
//                                           tdata: first_rise, second_rise,
//                                                  first_fall, second_fall
// m_axis    out  m_axis_tvalid/tready       tuser: channel_out, status
//                                           tdata: duty, period, zero pad
// cfg       in   cfg_valid/cfg_ready        cfg_data: timeout_reload
//
// A poll whose edges pass raises m_axis_tvalid after the edge checker, the divider load,
// the shared restoring divider for duty and the store.
// Rejected edges raise it after the edge checker; a poll without captures, or for an unused
// channel, raises it straight from idle. One poll at a time: s_axis_tready returns the
// cycle after the result transaction.
// Synchronous reset clears all channel state and loads timeout_reload with 20.
module pwm_capture_duty_period_unit
  import pcdp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // first_rise, second_rise, first_fall, second_fall
  input  logic [IN_USER_W-1:0]  s_axis_tuser,  // channel, captures_ready
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // duty, period, zero pad
  output logic [OUT_USER_W-1:0] m_axis_tuser,  // channel_out, status
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [TIMEOUT_W-1:0]  cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t state;

  logic [TIMEOUT_W-1:0] timeout_reload;
  logic [TIMEOUT_W-1:0] timeout_count [CHANNELS];
  logic [TIME_W-1:0]    stored_period [CHANNELS];
  logic [DUTY_W-1:0]    stored_duty [CHANNELS];

  logic [CHAN_W-1:0]  chan;
  logic [CH_W-1:0]    idx;
  logic [TIME_W-1:0]  pend_period;
  logic [CHAN_W-1:0]  out_chan;
  status_t            out_status;
  logic [DUTY_W-1:0]  out_duty;
  logic [TIME_W-1:0]  out_period;

  logic [CHAN_W-1:0]  in_chan;
  logic               in_ready;
  logic               in_range;
  logic               accept;
  logic [CH_W-1:0]    addr;
  logic               chk_start;
  logic               chk_done;
  chk_result_t        chk_res;
  logic               div_start;
  logic               div_done;
  logic [DUTY_W-1:0]  div_quo;

  assign in_chan = s_axis_tuser[CHAN_W-1:0];
  assign in_ready = s_axis_tuser[CHAN_W];
  assign in_range = 32'(in_chan) < CHANNELS;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = state == ST_IDLE;
  assign cfg_ready = 1'b1;
  assign addr = (state == ST_IDLE) ? CH_W'(in_chan) : idx;
  assign chk_start = accept && in_range && in_ready;
  assign div_start = (state == ST_CHECK) && chk_done && chk_res.valid;

  assign m_axis_tvalid = state == ST_OUT;
  assign m_axis_tuser = {out_status, out_chan};
  assign m_axis_tdata = OUT_DATA_W'({out_period, out_duty});

  pcdp_edge_check u_check (
    .clk    (clk),
    .rst    (rst),
    .start  (chk_start),
    .edges  (s_axis_tdata),
    .done   (chk_done),
    .result (chk_res)
  );

  pcdp_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (chk_res.num),
    .den   (chk_res.period),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      timeout_reload <= TIMEOUT_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        timeout_count[i] <= '0;
        stored_period[i] <= '0;
        stored_duty[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout_reload <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!in_range) begin
              state <= ST_OUT;
            end else if (in_ready) begin
              timeout_count[addr] <= timeout_reload;
              state <= ST_CHECK;
            end else if (timeout_count[addr] != '0) begin
              timeout_count[addr] <= timeout_count[addr] - 1'b1;
              state <= ST_OUT;
            end else begin
              stored_period[addr] <= '0;
              stored_duty[addr] <= '0;
              state <= ST_OUT;
            end
          end
        end
        ST_CHECK: begin
          if (chk_done) begin
            state <= chk_res.valid ? ST_DIV : ST_OUT;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            stored_period[addr] <= pend_period;
            stored_duty[addr] <= div_quo;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          chan <= in_chan;
          idx <= CH_W'(in_chan);
          out_chan <= in_chan;
          if (!in_range) begin
            out_status <= STAT_REJECT;
            out_duty <= '0;
            out_period <= '0;
          end else if (!in_ready && timeout_count[addr] != '0) begin
            out_status <= STAT_WAIT;
            out_duty <= stored_duty[addr];
            out_period <= stored_period[addr];
          end else if (!in_ready) begin
            out_status <= STAT_LOST;
            out_duty <= '0;
            out_period <= '0;
          end
        end
      end
      ST_CHECK: begin
        if (chk_done) begin
          pend_period <= chk_res.period;
          out_chan <= chan;
          if (!chk_res.valid) begin
            out_status <= STAT_REJECT;
            out_duty <= stored_duty[addr];
            out_period <= stored_period[addr];
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          out_status <= STAT_ACCEPT;
          out_duty <= div_quo;
          out_period <= pend_period;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
